FILE: rtl/core/pdld_pkg.sv
package pdld_pkg;

    localparam int SLOT_W = 4;
    localparam logic [SLOT_W-1:0] NONE_SLOT = 4'd15;

    typedef enum logic [2:0] {
        FN_ALLOC       = 3'd0,
        FN_ADD_TAIL    = 3'd1,
        FN_ADD_HEAD    = 3'd2,
        FN_REMOVE_HEAD = 3'd3,
        FN_REMOVE_TAIL = 3'd4,
        FN_MARK_DEAD   = 3'd5,
        FN_SWEEP_DEAD  = 3'd6,
        FN_QUERY       = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_INUSE = 2'd2
    } status_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [SLOT_W-1:0] data;
    } link_wr_t;

endpackage

FILE: rtl/core/pdld_link_mem.sv
module pdld_link_mem #(
    parameter int SLOTS = 10
) (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [pdld_pkg::SLOT_W-1:0] rd_addr,
    input  pdld_pkg::link_wr_t        next_wr,
    input  pdld_pkg::link_wr_t        prev_wr,
    output logic [pdld_pkg::SLOT_W-1:0] next_q,
    output logic [pdld_pkg::SLOT_W-1:0] prev_q
);
    import pdld_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);

    logic [SLOT_W-1:0] next_mem [SLOTS];
    logic [SLOT_W-1:0] prev_mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (next_wr.en)
        begin
            next_mem[next_wr.addr[IDX_W-1:0]] <= next_wr.data;
        end
        if (prev_wr.en)
        begin
            prev_mem[prev_wr.addr[IDX_W-1:0]] <= prev_wr.data;
        end
        if (rd_en)
        begin
            next_q <= next_mem[rd_addr[IDX_W-1:0]];
            prev_q <= prev_mem[rd_addr[IDX_W-1:0]];
        end
    end

endmodule

FILE: rtl/core/pooled_doubly_linked_deque_top.sv
// Each beat is decoded in S_DEC; alloc, mark dead and query then go to S_FIN.
// On a non-empty list add passes through S_LINK2, remove through S_UNLINK, and
// sweep walks up to SLOTS entries in S_SWEEP, one entry per step. One beat at a
// time: the next beat is taken in the cycle after the result is loaded.
// Reset (rst_n low, asynchronous) empties the list and clears in-use and dead
// flags at once; the link memory needs no clearing pass.
module pooled_doubly_linked_deque_top #(
    parameter int SLOTS = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  func,
    input  logic [pdld_pkg::SLOT_W-1:0] slot,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  status,
    output logic [pdld_pkg::SLOT_W-1:0] result_slot,
    output logic                        is_head,
    output logic                        is_tail,
    output logic                        is_dead,
    output logic [pdld_pkg::SLOT_W-1:0] count
);
    import pdld_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [SLOT_W-1:0] SLOT_LIM = SLOT_W'(SLOTS);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DEC    = 6'b000010,
        S_LINK2  = 6'b000100,
        S_UNLINK = 6'b001000,
        S_SWEEP  = 6'b010000,
        S_FIN    = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [2:0]        func_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] tail_reg, tail_next;
    logic [SLOT_W-1:0] cnt_reg, cnt_next;
    logic [SLOTS-1:0]  in_use_reg, in_use_next;
    logic [SLOTS-1:0]  dead_reg, dead_next;
    logic [SLOT_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0]  walk_reg, walk_next;
    logic              fwd_valid_reg, fwd_valid_next;
    logic [SLOT_W-1:0] fwd_prev_reg, fwd_prev_next;
    logic [1:0]        st_reg, st_next;
    logic [SLOT_W-1:0] res_reg, res_next;
    logic              qh_reg, qh_next, qt_reg, qt_next, qd_reg, qd_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        status_reg;
    logic [SLOT_W-1:0] result_reg, count_reg;
    logic              is_head_reg, is_tail_reg, is_dead_reg;

    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    link_wr_t          next_wr, prev_wr;
    logic [SLOT_W-1:0] next_q, prev_q;
    logic [SLOT_W-1:0] p_eff, n_eff;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              slot_ok, accept, out_load;

    pdld_link_mem #(.SLOTS(SLOTS)) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .next_wr (next_wr),
        .prev_wr (prev_wr),
        .next_q  (next_q),
        .prev_q  (prev_q)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_load = (state_reg == S_FIN) && (!out_valid_reg || out_ready);
    assign slot_ok  = (slot_reg < SLOT_LIM);

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = NONE_SLOT;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        p_eff = (state_reg == S_SWEEP && fwd_valid_reg) ? fwd_prev_reg : prev_q;
        n_eff = next_q;
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        cnt_next       = cnt_reg;
        in_use_next    = in_use_reg;
        dead_next      = dead_reg;
        cur_next       = cur_reg;
        walk_next      = walk_reg;
        fwd_valid_next = 1'b0;
        fwd_prev_next  = fwd_prev_reg;
        st_next        = st_reg;
        res_next       = res_reg;
        qh_next        = qh_reg;
        qt_next        = qt_reg;
        qd_next        = qd_reg;
        out_valid_next = out_valid_reg && !out_ready;
        rd_en          = 1'b0;
        rd_addr        = cur_reg;
        next_wr        = '0;
        prev_wr        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                st_next    = ST_OK;
                res_next   = NONE_SLOT;
                qh_next    = 1'b0;
                qt_next    = 1'b0;
                qd_next    = 1'b0;
                state_next = S_FIN;
                case (func_reg)
                    FN_ALLOC:
                    begin
                        if (free_found)
                        begin
                            dead_next[free_idx[IDX_W-1:0]] = 1'b0;
                            res_next = free_idx;
                        end
                        else
                        begin
                            st_next = ST_EMPTY;
                        end
                    end
                    FN_ADD_TAIL, FN_ADD_HEAD:
                    begin
                        if (!slot_ok || in_use_reg[slot_reg[IDX_W-1:0]])
                        begin
                            st_next = ST_INUSE;
                        end
                        else
                        begin
                            in_use_next[slot_reg[IDX_W-1:0]] = 1'b1;
                            cnt_next = cnt_reg + SLOT_W'(1);
                            res_next = slot_reg;
                            next_wr.en   = 1'b1;
                            next_wr.addr = slot_reg;
                            prev_wr.en   = 1'b1;
                            prev_wr.addr = slot_reg;
                            if (!(head_reg < SLOT_LIM) || !(tail_reg < SLOT_LIM))
                            begin
                                head_next    = slot_reg;
                                tail_next    = slot_reg;
                                next_wr.data = NONE_SLOT;
                                prev_wr.data = NONE_SLOT;
                            end
                            else if (func_reg == FN_ADD_TAIL)
                            begin
                                next_wr.data = NONE_SLOT;
                                prev_wr.data = tail_reg;
                                state_next   = S_LINK2;
                            end
                            else
                            begin
                                next_wr.data = head_reg;
                                prev_wr.data = NONE_SLOT;
                                state_next   = S_LINK2;
                            end
                        end
                    end
                    FN_REMOVE_HEAD, FN_REMOVE_TAIL:
                    begin
                        cur_next = (func_reg == FN_REMOVE_HEAD) ? head_reg : tail_reg;
                        if (cur_next < SLOT_LIM)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = cur_next;
                            state_next = S_UNLINK;
                        end
                        else
                        begin
                            st_next = ST_EMPTY;
                        end
                    end
                    FN_MARK_DEAD:
                    begin
                        if (slot_ok)
                        begin
                            dead_next[slot_reg[IDX_W-1:0]] = 1'b1;
                        end
                        else
                        begin
                            st_next = ST_INUSE;
                        end
                    end
                    FN_SWEEP_DEAD:
                    begin
                        cur_next  = head_reg;
                        walk_next = CNT_W'(1);
                        if (head_reg < SLOT_LIM)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = head_reg;
                            state_next = S_SWEEP;
                        end
                    end
                    default:
                    begin
                        if (slot_ok)
                        begin
                            qh_next = (head_reg < SLOT_LIM) && (head_reg == slot_reg);
                            qt_next = (tail_reg < SLOT_LIM) && (tail_reg == slot_reg);
                            qd_next = dead_reg[slot_reg[IDX_W-1:0]];
                        end
                        else
                        begin
                            st_next = ST_INUSE;
                        end
                    end
                endcase
            end
            S_LINK2:
            begin
                // hook the old end up to the new slot
                if (func_reg == FN_ADD_TAIL)
                begin
                    next_wr   = '{en: 1'b1, addr: tail_reg, data: slot_reg};
                    tail_next = slot_reg;
                end
                else
                begin
                    prev_wr   = '{en: 1'b1, addr: head_reg, data: slot_reg};
                    head_next = slot_reg;
                end
                state_next = S_FIN;
            end
            S_UNLINK, S_SWEEP:
            begin
                if (state_reg == S_UNLINK || dead_reg[cur_reg[IDX_W-1:0]])
                begin
                    if (p_eff < SLOT_LIM)
                    begin
                        next_wr = '{en: 1'b1, addr: p_eff, data: n_eff};
                    end
                    else
                    begin
                        head_next = n_eff;
                    end
                    if (n_eff < SLOT_LIM)
                    begin
                        prev_wr = '{en: 1'b1, addr: n_eff, data: p_eff};
                    end
                    else
                    begin
                        tail_next = p_eff;
                    end
                    if (cnt_reg != '0)
                    begin
                        cnt_next = cnt_reg - SLOT_W'(1);
                    end
                    in_use_next[cur_reg[IDX_W-1:0]] = 1'b0;
                    // prev of the following entry was just rewritten: forward it
                    fwd_valid_next = 1'b1;
                    fwd_prev_next  = p_eff;
                end
                if (state_reg == S_UNLINK)
                begin
                    res_next   = (func_reg == FN_REMOVE_HEAD) ? head_next : tail_next;
                    state_next = S_FIN;
                end
                else if ((n_eff < SLOT_LIM) && (walk_reg != CNT_W'(SLOTS)))
                begin
                    cur_next  = n_eff;
                    walk_next = walk_reg + CNT_W'(1);
                    rd_en     = 1'b1;
                    rd_addr   = n_eff;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= NONE_SLOT;
            tail_reg      <= NONE_SLOT;
            cnt_reg       <= '0;
            in_use_reg    <= '0;
            dead_reg      <= '0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cnt_reg       <= cnt_next;
            in_use_reg    <= in_use_next;
            dead_reg      <= dead_next;
            fwd_valid_reg <= fwd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            slot_reg <= slot;
        end
        cur_reg      <= cur_next;
        walk_reg     <= walk_next;
        fwd_prev_reg <= fwd_prev_next;
        st_reg       <= st_next;
        res_reg      <= res_next;
        qh_reg       <= qh_next;
        qt_reg       <= qt_next;
        qd_reg       <= qd_next;
        if (out_load)
        begin
            status_reg  <= st_reg;
            result_reg  <= res_reg;
            is_head_reg <= qh_reg;
            is_tail_reg <= qt_reg;
            is_dead_reg <= qd_reg;
            count_reg   <= cnt_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign result_slot = result_reg;
    assign is_head     = is_head_reg;
    assign is_tail     = is_tail_reg;
    assign is_dead     = is_dead_reg;
    assign count       = count_reg;

endmodule

FILE: rtl/core/pdld_checker.sv
module pdld_checker #(
    parameter int SLOTS = 10
) (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status,
    input logic [3:0] result_slot,
    input logic [3:0] count
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_slot) && $stable(status))
        else $error("result beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second beat taken while busy");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count <= 4'(SLOTS))
        else $error("count above pool size");

    a_fail_none: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != 2'd0 |-> result_slot == 4'd15)
        else $error("failed operation reports a slot");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("undefined status code");

endmodule

bind pooled_doubly_linked_deque_top pdld_checker #(.SLOTS(SLOTS)) u_pdld_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .result_slot (result_slot),
    .count       (count)
);
